// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is suspended while reset is asserted.
`define PIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PIA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/pia_pkg.sv -----
// Package with types and constants of the positional insert array.
package pia_pkg;

  // Default number of entries in the element store.
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths.
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned IN_TD_W  = 40;
  localparam int unsigned OUT_TD_W = 40;

  // Input kinds carried on tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_ELEMENT  = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_INSERTED = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_FULL     = 3'd4
  } pia_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_RESP,
    S_LIST_RD,
    S_LIST_OUT
  } pia_state_t;

endpackage

// ----- src/pia_store.sv -----
// Element store: one write port and one read port with registered read data.
module pia_store #(
  parameter int unsigned DEPTH = pia_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [pia_pkg::VAL_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [pia_pkg::VAL_W-1:0] rdata
);
  import pia_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/positional_insert_array_top.sv -----
// Top level of the positional insert array: sequencer, count and result register.
// Insert that goes in: the entries from the position upward move up one place, top first;
// the store moves one entry at a time (read, then write back), then takes the new value.
// Rejected insert or empty listing: one status word. Listing: each element read, then sent.
// One word is worked at a time; in_tready is high only while the sequencer idles.
// Synchronous active-low reset empties the store (count 0); no clearing pass.
module positional_insert_array_top #(
  parameter int unsigned CAPACITY = pia_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel. tdata: position [6:0], value [38:7], zero [39]. tuser: cmd.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pia_pkg::IN_TD_W-1:0]  in_tdata,
  input  logic                         in_tuser,
  // Result channel. tdata: status [2:0], element [34:3], zero [39:35].
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [pia_pkg::OUT_TD_W-1:0] out_tdata,
  output logic                         out_tlast
);
  import pia_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  pia_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;

  logic              out_valid_r, out_valid_nxt;
  pia_status_t       out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_elem_r, out_elem_nxt;
  logic              out_last_r, out_last_nxt;
  pia_status_t       resp_r, resp_nxt;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [VAL_W-1:0]  mem_wdata, mem_rdata;

  logic              in_acc;
  logic              out_free;
  logic [CW-1:0]     idx_dec;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign idx_dec  = idx_r - CW'(1);

  pia_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      pos_r <= in_tdata[POS_W-1:0];
      val_r <= in_tdata[POS_W +: VAL_W];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      resp_r      <= STAT_INSERTED;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      resp_r      <= resp_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Sequencer: next state, store port and result register loads.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[AW-1:0];
    in_tready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (cmd_r == CMD_LIST) begin
          idx_nxt = '0;
          if (count_r == '0) begin
            resp_nxt  = STAT_EMPTY;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_LIST_RD;
          end
        end else if (pos_r > POS_W'(count_r)) begin
          resp_nxt  = STAT_BADPOS;
          state_nxt = S_RESP;
        end else if (count_r == CW'(CAPACITY)) begin
          resp_nxt  = STAT_FULL;
          state_nxt = S_RESP;
        end else begin
          idx_nxt = count_r;
          if (POS_W'(count_r) > pos_r) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end

      // Fetch the entry just below the current slot.
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_dec[AW-1:0];
        state_nxt = S_SHIFT_WR;
      end

      // Move it up one place and step down.
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_dec;
        if (POS_W'(idx_dec) > pos_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        resp_nxt  = STAT_INSERTED;
        state_nxt = S_RESP;
      end

      // Single status word for an insert or an empty listing.
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_elem_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_LIST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r[AW-1:0];
        state_nxt = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_ELEMENT;
          out_elem_nxt   = mem_rdata;
          out_last_nxt   = (idx_r + CW'(1)) == count_r;
          idx_nxt        = idx_r + CW'(1);
          if ((idx_r + CW'(1)) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LIST_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output ports.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TD_W - STAT_W - VAL_W)'(0), out_elem_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- src/pia_checker.sv -----
// Port-level checker for the positional insert array, bound to the top level.
`include "assert_macros.svh"

module pia_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [pia_pkg::IN_TD_W-1:0]  in_tdata,
  input logic                         in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [pia_pkg::OUT_TD_W-1:0] out_tdata,
  input logic                         out_tlast
);
  import pia_pkg::*;

  // Reset drops any pending result.
  `PIA_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid, "out_tvalid high after reset")

  // A stalled result word holds.
  `PIA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Status words are single results, so they always close the answer.
  `PIA_ASSERT(a_status_last, out_tvalid && out_tdata[2:0] != STAT_ELEMENT |-> out_tlast && out_tdata[34:3] == 32'd0, "status word not last or element nonzero")

  // One word at a time: the block is busy right after an accept.
  `PIA_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted a word while busy")

  // The padding bits stay zero.
  `PIA_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[39:35] == 5'd0, "padding bits nonzero")

endmodule

bind positional_insert_array_top pia_checker u_pia_checker (.*);

// ----- verif/tb_positional_insert_array_top.sv -----
// Self-checking testbench for the positional insert array top level.
module tb_positional_insert_array_top;
  import pia_pkg::*;

  // One expected word on the result channel.
  typedef struct {
    pia_status_t      status;
    logic [VAL_W-1:0] element;
    logic             last;
  } pia_result_t;

  // Shadow copy of the array; predicts the result words of every accepted input word.
  class pia_shadow_array;
    logic [VAL_W-1:0] shadow_vals [CAPACITY_DEF];
    int unsigned      shadow_count;
    pia_result_t      pending_results [$];
    int unsigned      mismatches;

    function new();
      shadow_count = 0;
      mismatches   = 0;
    endfunction

    // Apply an accepted input word to the shadow array and queue its results.
    function void note_word(logic cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      pia_result_t r;
      int unsigned i;
      r.element = '0;
      r.last    = 1'b1;
      if (cmd == CMD_INSERT) begin
        // The position test wins over the full test.
        if (pos > shadow_count) begin
          r.status = STAT_BADPOS;
        end else if (shadow_count >= CAPACITY_DEF) begin
          r.status = STAT_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) begin
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_vals[pos] = val;
          shadow_count++;
          r.status = STAT_INSERTED;
        end
        pending_results.push_back(r);
      end else if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
        pending_results.push_back(r);
      end else begin
        for (i = 0; i < shadow_count; i++) begin
          r.status  = STAT_ELEMENT;
          r.element = shadow_vals[i];
          r.last    = (i + 1 == shadow_count);
          pending_results.push_back(r);
        end
      end
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_word(logic [OUT_TD_W-1:0] td, logic tl);
      pia_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: unexpected result word status=%0d element=%h last=%b",
                   td[2:0], td[34:3], tl);
        return;
      end
      want = pending_results.pop_front();
      if (td[2:0] !== want.status || td[34:3] !== want.element || tl !== want.last ||
          td[39:35] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"MISMATCH: exp status=%0d element=%h last=%b, ",
                    "got status=%0d element=%h last=%b pad=%h"},
                   want.status, want.element, want.last,
                   td[2:0], td[34:3], tl, td[39:35]);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_TD_W-1:0] out_tdata;
  logic                out_tlast;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  pia_shadow_array sb = new();

  positional_insert_array_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata, out_tlast);
  end

  // Present one input word, with random idle cycles ahead of it, until it is taken.
  task automatic send_word(logic cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {1'b0, val, pos};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, pos, val);
    @(negedge clk);
  endtask

  // Hold the sender off until every expected result word has come back.
  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Random value, weighted toward the extremes.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned idle_tbl  [4];
    int unsigned stall_tbl [4];
    int unsigned sel;
    logic [POS_W-1:0] pos;

    idle_tbl   = '{0, 54, 0, 16};
    stall_tbl  = '{0, 0, 54, 16};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_INSERT;
    out_tready = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty listing, bad positions on an empty store, then edge inserts.
    send_word(CMD_LIST,   7'd0,   32'h0);
    send_word(CMD_INSERT, 7'd1,   32'h1234_5678);
    send_word(CMD_INSERT, 7'd127, 32'hDEAD_BEEF);
    send_word(CMD_INSERT, 7'd0,   32'h8000_0000);
    send_word(CMD_INSERT, 7'd1,   32'h7FFF_FFFF);
    send_word(CMD_INSERT, 7'd0,   32'hFFFF_FFFF);
    send_word(CMD_INSERT, 7'd1,   32'h0000_0000);
    send_word(CMD_INSERT, 7'd4,   32'h0000_0001);
    send_word(CMD_INSERT, 7'd6,   32'h5555_AAAA);
    send_word(CMD_LIST,   7'd127, 32'hFFFF_FFFF);
    wait_drain();

    // Random: mostly valid inserts and listings, some bad positions.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tbl[ph];
      recv_stall_pct = stall_tbl[ph];
      for (int n = 0; n < 120; n++) begin
        sel = $urandom_range(99);
        if (sel < 35) begin
          send_word(CMD_LIST, 7'($urandom), $urandom);
        end else if (sel < 60) begin
          pos = 7'($urandom_range(127, sb.shadow_count + 1));
          send_word(CMD_INSERT, pos, pick_value());
        end else begin
          pos = 7'($urandom_range(sb.shadow_count, 0));
          send_word(CMD_INSERT, pos, pick_value());
        end
      end
      wait_drain();
    end

    // Directed on a full store: full answers, and a bad position that wins over full.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sb.shadow_count < CAPACITY_DEF)
      send_word(CMD_INSERT, 7'($urandom_range(sb.shadow_count, 0)), pick_value());
    send_word(CMD_INSERT, 7'd0,   32'h1111_1111);
    send_word(CMD_INSERT, 7'd64,  32'h2222_2222);
    send_word(CMD_INSERT, 7'd65,  32'h3333_3333);
    send_word(CMD_INSERT, 7'd127, 32'h4444_4444);
    send_word(CMD_LIST,   7'd0,   32'h0);
    in_tvalid = 1'b0;

    // Let the last results drain, then allow for a full-depth shift.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);

    if (sb.pending_results.size() != 0)
      $display("%0d expected result words never arrived", sb.pending_results.size());
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
